>>> rtl/core/psn_pkg.sv
// Shared types and constants for the 2D point set normalization unit.
// No dependencies; every other file of the block but psn_ram imports this package.
package psn_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 12;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int POINT_W    = 2 * COORD_BITS;
  localparam int SUM_W      = COORD_BITS + IDX_W;
  localparam int CTR_W      = COORD_BITS + 8;
  localparam int DIFF_W     = CTR_W + 2;
  localparam int SCALE_W    = 24;
  localparam int DIV_W      = SUM_W + 8;
  localparam int DVSR_W     = CTR_W + 1;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int PROD_W     = SCALE_W + 1 + DIFF_W;
  localparam int NORM_W     = 24;
  localparam int OFS_W      = 32;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = 1;
  localparam int OUT_DATA_W = 184;

  // One closed point set handed from the loader to the compute side.
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sum_u;
    logic [SUM_W-1:0] sum_v;
  } job_t;

  typedef struct packed {
    logic busy;
  } back_stat_t;

endpackage

>>> rtl/core/point_set_normalize_2d_unit.sv
// Top level of the 2D point set normalization unit; needs psn_pkg, psn_ram,
// psn_queue, psn_front and psn_back. Points load at one per cycle while the
// unit is idle. After the final point: two divides for the centroid, a scan
// for the largest offset, the scale divide (skipped for a degenerate set),
// the offsets, then the points one at a time; input waits until the set is
// out. Synchronous reset leaves the store as is.
module point_set_normalize_2d_unit
  import psn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // point_u, point_v
  input  logic                  in_tlast,   // is_final
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // index, norm_u, norm_v, center_u, center_v, scale, offset_u, offset_v
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,  // run_end
  output logic                  out_tuser   // degenerate
);

  logic               q_push, q_pop, q_empty, q_full;
  job_t               push_job, pop_job;
  back_stat_t         back_stat;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [POINT_W-1:0] ram_wdata, ram_rdata;

  psn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_empty   (q_empty),
    .back_stat (back_stat),
    .q_push    (q_push),
    .q_job     (push_job),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  psn_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push && !q_full),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  psn_ram #(
    .WIDTH (POINT_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  psn_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_job      (pop_job),
    .q_pop      (q_pop),
    .back_stat  (back_stat),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

>>> rtl/core/psn_ram.sv
// Generic single write, single read port RAM with registered read data.
// No dependencies.
module psn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/psn_queue.sv
// Short job queue between the point loader and the compute sequencer.
// Depends on psn_pkg.
module psn_queue
  import psn_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t pop_job,
  output logic empty,
  output logic full
);

  job_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr_r, rptr_r;
  logic [Q_PTR_W:0]   cnt_r;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign pop_job = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wptr_r] <= push_job;
    end
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push && !full) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rptr_r <= rptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (Q_PTR_W+1)'(push && !full) - (Q_PTR_W+1)'(pop && !empty);
    end
  end

endmodule

>>> rtl/core/psn_front.sv
// Point loader: accepts points, writes the store, keeps count and sums.
// Depends on psn_pkg; pushes one job into psn_queue per closed set.
module psn_front
  import psn_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [23:0]        in_tdata,   // point_u, point_v
  input  logic               in_tlast,   // is_final
  input  logic               q_empty,
  input  back_stat_t         back_stat,
  output logic               q_push,
  output job_t               q_job,
  output logic               ram_we,
  output logic [IDX_W-1:0]   ram_waddr,
  output logic [POINT_W-1:0] ram_wdata
);

  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [SUM_W-1:0]      su_r, su_nxt, sv_r, sv_nxt;
  logic [COORD_BITS-1:0] pu, pv;
  logic                  acc, room;

  // The store is shared with the compute side, so a new set waits for it.
  assign in_tready = q_empty && !back_stat.busy;
  assign acc       = in_tvalid && in_tready;
  assign pu        = in_tdata[COORD_BITS-1:0];
  assign pv        = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign room      = (cnt_r < CNT_W'(MAX_POINTS));

  assign ram_we    = acc && room;
  assign ram_waddr = cnt_r[IDX_W-1:0];
  assign ram_wdata = {pv, pu};

  always_comb begin
    cnt_nxt = cnt_r;
    su_nxt  = su_r;
    sv_nxt  = sv_r;
    if (acc && room) begin
      cnt_nxt = cnt_r + 1'b1;
      su_nxt  = su_r + SUM_W'(pu);
      sv_nxt  = sv_r + SUM_W'(pv);
    end
  end

  assign q_push    = acc && in_tlast;
  assign q_job.cnt   = cnt_nxt;
  assign q_job.sum_u = su_nxt;
  assign q_job.sum_v = sv_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      su_r  <= '0;
      sv_r  <= '0;
    end else if (q_push) begin
      cnt_r <= '0;
      su_r  <= '0;
      sv_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      su_r  <= su_nxt;
      sv_r  <= sv_nxt;
    end
  end

endmodule

>>> rtl/core/psn_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on psn_pkg; shared by the centroid and scale computations.
module psn_div
  import psn_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [DVSR_W-1:0] divisor,
  output logic              done,
  output logic [DIV_W-1:0]  quotient
);

  logic                 busy_r, done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DVSR_W-1:0]    dvsr_r, rem_r, rem_nxt;
  logic [DIV_W-1:0]     quo_r;
  logic [DVSR_W:0]      trial;
  logic                 qbit;

  assign trial = {rem_r, quo_r[DIV_W-1]};

  always_comb begin
    qbit    = (trial >= {1'b0, dvsr_r});
    rem_nxt = qbit ? DVSR_W'(trial - {1'b0, dvsr_r}) : trial[DVSR_W-1:0];
  end

  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      dvsr_r <= divisor;
      rem_r  <= '0;
      quo_r  <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_W-2:0], qbit};
    end
  end

endmodule

>>> rtl/core/psn_back.sv
// Compute sequencer: centroid, largest u offset, scale, offsets, and the
// emission of every normalized point. Depends on psn_pkg and psn_div.
module psn_back
  import psn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  job_t                  q_job,
  output logic                  q_pop,
  output back_stat_t            back_stat,
  output logic [IDX_W-1:0]      ram_raddr,
  input  logic [POINT_W-1:0]    ram_rdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  output logic                  out_tuser
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIVU, S_DIVV, S_MRD, S_MCMP, S_DIVS, S_OFFU, S_OFFV, S_OFFW,
    S_ERD, S_EMU, S_EMV, S_ENV
  } state_t;

  localparam int RND_W = PROD_W - 8;

  state_t                  state_r;
  logic [CNT_W-1:0]        n_r;
  logic [SUM_W-1:0]        sv_r;
  logic [IDX_W-1:0]        idx_r;
  logic [CTR_W-1:0]        cu_r, cv_r;
  logic signed [DIFF_W-1:0] maxd_r, dv_r;
  logic [SCALE_W-1:0]      scale_r;
  logic                    degen_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [NORM_W-1:0] nu_r;
  logic signed [OFS_W-1:0]  offu_r, offv_r;

  logic                    div_start, div_done;
  logic [DIV_W-1:0]        div_dividend, div_q;
  logic [DVSR_W-1:0]       div_divisor;

  logic [COORD_BITS-1:0]   pu, pv;
  logic signed [DIFF_W-1:0] du, dv, dmax;
  logic signed [DIFF_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [RND_W-1:0]  rnd;
  logic signed [NORM_W-1:0] norm_sat;
  logic signed [OFS_W-1:0]  ofs_sat;
  logic                    last_pt, out_load;

  psn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign back_stat.busy = (state_r != S_IDLE);
  assign q_pop          = (state_r == S_IDLE) && !q_empty;
  assign ram_raddr      = idx_r;
  assign last_pt        = ({1'b0, idx_r} == n_r - 1'b1);

  assign pu = ram_rdata[COORD_BITS-1:0];
  assign pv = ram_rdata[2*COORD_BITS-1:COORD_BITS];
  assign du = $signed({2'b00, pu, 8'h00}) - $signed({2'b00, cu_r});
  assign dv = $signed({2'b00, pv, 8'h00}) - $signed({2'b00, cv_r});
  // Running maximum including the point being compared this cycle.
  assign dmax = (idx_r == '0 || du > maxd_r) ? du : maxd_r;

  // Divider operands: centroid sums while loading the job, then 2^24 / offset.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state_r)
      S_IDLE: begin
        div_start    = !q_empty;
        div_dividend = {q_job.sum_u, 8'h00} + DIV_W'(q_job.cnt >> 1);
        div_divisor  = DVSR_W'(q_job.cnt);
      end
      S_DIVU: begin
        div_start    = div_done;
        div_dividend = {sv_r, 8'h00} + DIV_W'(n_r >> 1);
        div_divisor  = DVSR_W'(n_r);
      end
      S_MCMP: begin
        // The scale divide starts as the last point is compared, if the largest offset is positive.
        div_start    = last_pt && (dmax > 0);
        div_dividend = (DIV_W'(1) << SCALE_W) + DIV_W'(dmax >>> 1);
        div_divisor  = DVSR_W'(dmax);
      end
      default: begin
      end
    endcase
  end

  // One multiplier, shared by the offset terms and the per-point products.
  always_comb begin
    unique case (state_r)
      S_OFFU:  mul_b = $signed({2'b00, cu_r});
      S_OFFV:  mul_b = $signed({2'b00, cv_r});
      S_EMU:   mul_b = du;
      default: mul_b = dv_r;
    endcase
    mul_p = $signed({1'b0, scale_r}) * mul_b;
  end

  always_comb begin
    rnd = RND_W'((prod_r + PROD_W'(128)) >>> 8);
    if (rnd > $signed(RND_W'((1 << (NORM_W - 1)) - 1))) begin
      norm_sat = {1'b0, {(NORM_W-1){1'b1}}};
    end else if (rnd < -$signed(RND_W'(1 << (NORM_W - 1)))) begin
      norm_sat = {1'b1, {(NORM_W-1){1'b0}}};
    end else begin
      norm_sat = NORM_W'(rnd);
    end
    // The offset product is never negative, so only the low bound can clip.
    if (rnd >= $signed(RND_W'(64'd1 << (OFS_W - 1)))) begin
      ofs_sat = {1'b1, {(OFS_W-1){1'b0}}};
    end else begin
      ofs_sat = -$signed(OFS_W'(rnd));
    end
  end

  assign out_load = (state_r == S_ENV) && (!out_tvalid || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      out_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            n_r     <= q_job.cnt;
            sv_r    <= q_job.sum_v;
            state_r <= S_DIVU;
          end
        end
        S_DIVU: begin
          if (div_done) begin
            cu_r    <= div_q[CTR_W-1:0];
            state_r <= S_DIVV;
          end
        end
        S_DIVV: begin
          if (div_done) begin
            cv_r    <= div_q[CTR_W-1:0];
            idx_r   <= '0;
            state_r <= S_MRD;
          end
        end
        S_MRD: begin
          state_r <= S_MCMP;
        end
        S_MCMP: begin
          maxd_r <= dmax;
          if (last_pt) begin
            state_r <= S_DIVS;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_MRD;
          end
        end
        S_DIVS: begin
          // Entered with the largest offset settled; a nonpositive one skips the divide.
          if (maxd_r <= 0) begin
            degen_r <= 1'b1;
            scale_r <= '0;
            state_r <= S_OFFU;
          end else if (div_done) begin
            degen_r <= 1'b0;
            scale_r <= div_q[SCALE_W] ? {SCALE_W{1'b1}} : div_q[SCALE_W-1:0];
            state_r <= S_OFFU;
          end
        end
        S_OFFU: begin
          prod_r  <= mul_p;
          state_r <= S_OFFV;
        end
        S_OFFV: begin
          offu_r  <= ofs_sat;
          prod_r  <= mul_p;
          state_r <= S_OFFW;
        end
        S_OFFW: begin
          offv_r  <= ofs_sat;
          idx_r   <= '0;
          state_r <= S_ERD;
        end
        S_ERD: begin
          state_r <= S_EMU;
        end
        S_EMU: begin
          prod_r  <= mul_p;
          dv_r    <= dv;
          state_r <= S_EMV;
        end
        S_EMV: begin
          nu_r    <= norm_sat;
          prod_r  <= mul_p;
          state_r <= S_ENV;
        end
        S_ENV: begin
          if (out_load) begin
            out_tdata  <= {2'b00, offv_r, offu_r, scale_r, cv_r, cu_r,
                           norm_sat, nu_r, idx_r};
            out_tlast  <= last_pt;
            out_tuser  <= degen_r;
            idx_r      <= idx_r + 1'b1;
            state_r    <= last_pt ? S_IDLE : S_ERD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for point_set_normalize_2d_unit.
// Depends on psn_pkg and the unit's RTL; streams point sets and checks every
// normalized point against a behavioral model of the normalization.
`timescale 1ns / 1ps

module tb_top;
  import psn_pkg::*;

  typedef struct packed {
    logic [5:0]  index;
    logic [23:0] norm_u;
    logic [23:0] norm_v;
    logic [19:0] center_u;
    logic [19:0] center_v;
    logic [23:0] scale;
    logic [31:0] offset_u;
    logic [31:0] offset_v;
    logic        degenerate;
    logic        run_end;
  } norm_point_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [23:0] in_tdata;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;
  logic out_tuser;

  point_set_normalize_2d_unit dut (.*);

  // Model state of the point loader.
  logic [23:0] set_points[MAX_POINTS];
  int unsigned set_count;
  int unsigned set_sum_u;
  int unsigned set_sum_v;

  norm_point_t expected_points[$];
  int unsigned mismatch_count;
  int unsigned checked_count;
  int unsigned sets_closed;
  int unsigned degenerate_sets;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint round_q24_to_q16(longint x);
    longint q;
    q = x + 128;
    if (q >= 0) return q >>> 8;
    return -((-q + 255) >>> 8);
  endfunction

  function automatic longint clamp_signed(longint x, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // Loads one point; on the closing point the whole set's results are queued.
  task automatic predict_point(logic [11:0] u, logic [11:0] v, logic fin);
    longint cu8;
    longint cv8;
    longint maxd;
    longint d;
    longint sc;
    longint ou;
    longint ov;
    norm_point_t r;
    bit degen;
    if (set_count < MAX_POINTS) begin
      set_points[set_count] = {v, u};
      set_count++;
      set_sum_u += 32'(u);
      set_sum_v += 32'(v);
    end
    if (!fin) return;
    cu8 = (longint'(set_sum_u) * 256 + set_count / 2) / set_count;
    cv8 = (longint'(set_sum_v) * 256 + set_count / 2) / set_count;
    maxd = 0;
    for (int i = 0; i < set_count; i++) begin
      d = (longint'(set_points[i][11:0]) <<< 8) - cu8;
      if (i == 0 || d > maxd) maxd = d;
    end
    degen = (maxd <= 0);
    sc = 0;
    ou = 0;
    ov = 0;
    if (!degen) begin
      sc = ((longint'(1) <<< 24) + maxd / 2) / maxd;
      if (sc > 24'hFFFFFF) sc = 24'hFFFFFF;
      ou = clamp_signed(-round_q24_to_q16(sc * cu8), 32);
      ov = clamp_signed(-round_q24_to_q16(sc * cv8), 32);
    end
    for (int i = 0; i < set_count; i++) begin
      r = '0;
      r.index = i[5:0];
      if (!degen) begin
        r.norm_u = 24'(clamp_signed(round_q24_to_q16(
          sc * ((longint'(set_points[i][11:0]) <<< 8) - cu8)), 24));
        r.norm_v = 24'(clamp_signed(round_q24_to_q16(
          sc * ((longint'(set_points[i][23:12]) <<< 8) - cv8)), 24));
      end
      r.center_u = cu8[19:0];
      r.center_v = cv8[19:0];
      r.scale = sc[23:0];
      r.offset_u = ou[31:0];
      r.offset_v = ov[31:0];
      r.degenerate = degen;
      r.run_end = (i + 1 == set_count);
      expected_points.insert(expected_points.size(), r);
    end
    sets_closed++;
    if (degen) degenerate_sets++;
    set_count = 0;
    set_sum_u = 0;
    set_sum_v = 0;
  endtask

  task automatic send_point(logic [11:0] u, logic [11:0] v, logic fin);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {v, u};
    in_tlast <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_point(u, v, fin);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic send_random_set(int n);
    int unsigned base_u;
    int unsigned base_v;
    int unsigned spread;
    spread = $urandom_range(4095, 1);
    base_u = $urandom_range(4095 - spread, 0);
    base_v = $urandom_range(4095, 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9, 0) == 0)
        send_point(12'($urandom_range(4095, 0)), 12'($urandom_range(4095, 0)),
                   i == n - 1);
      else
        send_point(12'(base_u + $urandom_range(spread, 0)),
                   12'($urandom_range(4095, 0)), i == n - 1);
    end
  endtask

  // Result checker: compares each transfer with the oldest expected point.
  always @(posedge clk) begin
    norm_point_t got;
    norm_point_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '0;
      {got.offset_v, got.offset_u, got.scale, got.center_v, got.center_u,
       got.norm_v, got.norm_u, got.index} = out_tdata[181:0];
      got.degenerate = out_tuser;
      got.run_end = out_tlast;
      checked_count++;
      if (expected_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_points.pop_front();
        if (got != want) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // Receiver stall pattern, including the long hold-off of the backpressure test.
  always @(posedge clk) begin
    if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(recv_stall_pct != 0 && $urandom_range(99, 0) < recv_stall_pct);
    end
  end

  task automatic test_directed();
    send_point(12'd7, 12'd9, 1'b1);                     // single point
    send_point(12'd100, 12'd0, 1'b0);
    send_point(12'd100, 12'd4095, 1'b1);                // equal u
    send_point(12'd0, 12'd0, 1'b0);
    send_point(12'd4095, 12'd4095, 1'b1);               // extremes
    send_point(12'd0, 12'd4095, 1'b0);
    send_point(12'd0, 12'd0, 1'b0);
    send_point(12'd1, 12'd2048, 1'b1);                  // one point off the rest
    send_point(12'd2730, 12'd1365, 1'b0);
    send_point(12'd1365, 12'd2730, 1'b0);
    send_point(12'd4094, 12'd1, 1'b1);
    wait_drained();
  endtask

  task automatic test_full_store();
    // Overfills the store; extra points are dropped but the final closes it.
    for (int i = 0; i < MAX_POINTS + 3; i++)
      send_point(12'($urandom_range(4095, 0)), 12'($urandom_range(4095, 0)),
                 i == MAX_POINTS + 2);
    wait_drained();
  endtask

  task automatic test_random(int unsigned idle, int unsigned stall, int items);
    int sent;
    int n;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    sent = 0;
    while (sent < items) begin
      n = ($urandom_range(15, 0) == 0) ? $urandom_range(64, 2) : $urandom_range(8, 1);
      send_random_set(n);
      sent += n;
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 600;
    for (int s = 0; s < 4; s++) send_random_set(20);
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    set_count = 0;
    set_sum_u = 0;
    set_sum_v = 0;
    mismatch_count = 0;
    checked_count = 0;
    sets_closed = 0;
    degenerate_sets = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_store();
    test_random(0, 0, 80);
    test_random(85, 0, 60);
    test_random(0, 85, 60);
    test_random(7, 7, 80);
    test_backpressure();
    $display("Covered %0d point sets (%0d degenerate), %0d normalized points checked.",
             sets_closed, degenerate_sets, checked_count);
    if (mismatch_count == 0 && expected_points.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("%0d mismatches, %0d points outstanding", mismatch_count,
               expected_points.size());
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/psn_pkg.sv
rtl/core/psn_ram.sv
rtl/core/psn_queue.sv
rtl/core/psn_front.sv
rtl/core/psn_div.sv
rtl/core/psn_back.sv
rtl/core/point_set_normalize_2d_unit.sv
verif/tb_top.sv
